// ===== design/hptc_pkg.sv =====
package hptc_pkg;

  localparam int CFG_IDX_W        = 3;
  localparam int COEF_FRAC        = 16;
  localparam int HEIGHT_FRAC_BITS = 8;
  localparam int PROD_LIM_LOG2    = 59;

  localparam int THR_LO     = 8192;
  localparam int THR_HI     = 32768;
  localparam int THR_SCALE  = 200;
  localparam int T200_LO    = THR_LO * THR_SCALE;
  localparam int T200_HI    = THR_HI * THR_SCALE;
  localparam int THR_BASE_RST = 16384;

  // floor(y/25) = (y * DIV25_MAGIC) >> DIV25_SHIFT for y < 2^20
  localparam int DIV25_MAGIC = 1342178;
  localparam int DIV25_SHIFT = 25;

  // floor(x/3) for x < 2^17 and x < 2^19
  localparam int DIV3_HI_MAGIC = 87382;
  localparam int DIV3_HI_SHIFT = 18;
  localparam int DIV3_LO_MAGIC = 349526;
  localparam int DIV3_LO_SHIFT = 20;
  localparam int DIV3_SPLIT    = 17;

  // floor(v*128/325) = (v * STICK_MAGIC) >> STICK_SHIFT
  localparam int STICK_MAGIC = 3303821;
  localparam int STICK_SHIFT = 23;
  localparam int STICK_MAX   = 5120;
  localparam int STICK_DEAD  = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A0,
    REG_COEF_A1,
    REG_COEF_B0,
    REG_COEF_B1,
    REG_COEF_B2,
    REG_THRUST_BASE,
    REG_HEIGHT_TARGET,
    REG_HEIGHT_EN
  } cfg_reg_t;

  // raw stick to Q6.8 degrees, clamped and deadbanded
  function automatic logic signed [13:0] stick_scale(input logic signed [14:0] raw);
    logic [14:0] mag;
    logic [36:0] prod;
    logic [13:0] q;
    logic [13:0] lim;
    mag  = raw[14] ? 15'(-raw) : 15'(raw);
    prod = 37'(mag) * 37'(STICK_MAGIC);
    q    = prod[36:STICK_SHIFT];
    lim  = (q > 14'(STICK_MAX)) ? 14'(STICK_MAX) : q;
    if (lim < 14'(STICK_DEAD)) begin
      lim = '0;
    end
    return raw[14] ? -signed'(lim) : signed'(lim);
  endfunction

endpackage

// ===== design/height_pidt1_thrust_controller.sv =====
// A request accepted at a clock edge passes six register stages, each with its own
//   valid bit, on its way to out_*.
// Throughput: one request per cycle unless out_stall holds the pipeline; the filter history loop closes in stage 3.
// out_stall ripples back through full stages to in_stall in the same cycle.
// Reset (rst_n low, synchronous): valids and filter history cleared, registers
//   back to their defaults (thrust base 0.5, height loop off).
module height_pidt1_thrust_controller import hptc_pkg::*; #(
  parameter int COEF_WIDTH = 32,
  localparam int CFG_DW = (COEF_WIDTH > 24) ? COEF_WIDTH : 24
) (
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DW-1:0]        cfg_wdata,

  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [23:0]       in_height_measured,
  input  logic signed [14:0]       in_stick_roll,
  input  logic signed [14:0]       in_stick_pitch,

  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [15:0]              out_thrust_cmd,
  output logic signed [13:0]       out_roll_cmd,
  output logic signed [13:0]       out_pitch_cmd,
  output logic                     out_thrust_limited
);

  localparam int BW = COEF_WIDTH + 2;
  localparam int PW = BW + 32;
  localparam int XW = (PW > 62) ? PW : 62;

  // floor(a*b / 2^sh), clamped to +-2^59
  function automatic logic signed [60:0] mul_shift(input logic signed [BW-1:0] a,
                                                   input logic signed [31:0] b,
                                                   input logic [4:0] sh);
    logic signed [PW-1:0] p;
    logic signed [XW-1:0] px;
    logic signed [XW-1:0] lim;
    p   = PW'(a) * PW'(b);
    px  = XW'(p >>> sh);
    lim = '0;
    lim[PROD_LIM_LOG2] = 1'b1;
    if (px > lim) begin
      return 61'(lim);
    end else if (px < -lim) begin
      return 61'(-lim);
    end
    return 61'(px);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [62:0] v);
    if (v > 63'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -63'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(v);
  endfunction

  // configuration
  logic signed [COEF_WIDTH-1:0] coef_a0_r, coef_a1_r, coef_b0_r, coef_b1_r, coef_b2_r;
  logic [15:0]                  thrust_base_r;
  logic signed [23:0]           height_target_r;
  logic                         height_en_r;
  logic signed [BW-1:0]         bsum_r;
  logic [23:0]                  base200_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a0_r       <= '0;
      coef_a1_r       <= '0;
      coef_b0_r       <= '0;
      coef_b1_r       <= '0;
      coef_b2_r       <= '0;
      thrust_base_r   <= 16'(THR_BASE_RST);
      height_target_r <= '0;
      height_en_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_A0:       coef_a0_r       <= cfg_wdata[COEF_WIDTH-1:0];
        REG_COEF_A1:       coef_a1_r       <= cfg_wdata[COEF_WIDTH-1:0];
        REG_COEF_B0:       coef_b0_r       <= cfg_wdata[COEF_WIDTH-1:0];
        REG_COEF_B1:       coef_b1_r       <= cfg_wdata[COEF_WIDTH-1:0];
        REG_COEF_B2:       coef_b2_r       <= cfg_wdata[COEF_WIDTH-1:0];
        REG_THRUST_BASE:   thrust_base_r   <= cfg_wdata[15:0];
        REG_HEIGHT_TARGET: height_target_r <= cfg_wdata[23:0];
        REG_HEIGHT_EN:     height_en_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // derived from config, settled long before a request reaches its user stage
  always_ff @(posedge clk) begin
    bsum_r    <= BW'(coef_b0_r) + BW'(coef_b1_r) + BW'(coef_b2_r);
    base200_r <= 24'(thrust_base_r) * 24'(THR_SCALE);
  end

  // pipeline control
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6     = !out_valid_r || !out_stall;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r        <= in_valid;
      if (rdy2) v2_r        <= v1_r;
      if (rdy3) v3_r        <= v2_r;
      if (rdy4) v4_r        <= v3_r;
      if (rdy5) v5_r        <= v4_r;
      if (rdy6) out_valid_r <= v5_r;
    end
  end

  // stage 1: height error
  logic signed [24:0] err_diff;
  logic signed [23:0] err_nxt;
  logic signed [23:0] s1_err_r;
  logic signed [14:0] s1_roll_r, s1_pitch_r;

  always_comb begin
    err_diff = 25'(height_target_r) - 25'(in_height_measured);
    if (err_diff[24] != err_diff[23]) begin
      err_nxt = err_diff[24] ? 24'sh800000 : 24'sh7FFFFF;
    end else begin
      err_nxt = err_diff[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_err_r   <= err_nxt;
      s1_roll_r  <= in_stick_roll;
      s1_pitch_r <= in_stick_pitch;
    end
  end

  // stage 2: numerator terms, error history
  logic signed [23:0] err_hist_1_r, err_hist_2_r;
  logic signed [61:0] bterm_nxt, s2_bterm_r;
  logic signed [25:0] s2_esum_r;
  logic signed [13:0] s2_roll_r, s2_pitch_r;

  assign bterm_nxt =
      62'(mul_shift(BW'(coef_b2_r), 32'(s1_err_r), 5'(HEIGHT_FRAC_BITS)))
    + 62'(mul_shift(BW'(coef_b1_r), 32'(err_hist_1_r), 5'(HEIGHT_FRAC_BITS)))
    + 62'(mul_shift(BW'(coef_b0_r), 32'(err_hist_2_r), 5'(HEIGHT_FRAC_BITS)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_hist_1_r <= '0;
      err_hist_2_r <= '0;
    end else if (rdy2 && v1_r) begin
      err_hist_1_r <= s1_err_r;
      err_hist_2_r <= err_hist_1_r;
    end
  end

  // error sum from the history before it shifts: e + e + e1
  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_bterm_r <= bterm_nxt;
      s2_esum_r  <= 26'(s1_err_r) + 26'(s1_err_r) + 26'(err_hist_1_r);
      s2_roll_r  <= stick_scale(s1_roll_r);
      s2_pitch_r <= stick_scale(s1_pitch_r);
    end
  end

  // stage 3: filter output, output history, raw correction product
  logic signed [31:0] out_hist_1_r, out_hist_2_r;
  logic signed [62:0] acc;
  logic signed [31:0] u_nxt, s3_u_r;
  logic signed [60:0] s3_corr0_r;
  logic signed [13:0] s3_roll_r, s3_pitch_r;

  always_comb begin
    acc = 63'(s2_bterm_r)
        - 63'(mul_shift(BW'(coef_a1_r), out_hist_1_r, 5'(COEF_FRAC)))
        - 63'(mul_shift(BW'(coef_a0_r), out_hist_2_r, 5'(COEF_FRAC)));
    u_nxt = height_en_r ? sat32(acc) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_hist_1_r <= '0;
      out_hist_2_r <= '0;
    end else if (rdy3 && v2_r) begin
      out_hist_1_r <= u_nxt;
      out_hist_2_r <= out_hist_1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_u_r     <= u_nxt;
      s3_corr0_r <= mul_shift(bsum_r, 32'(s2_esum_r), 5'(HEIGHT_FRAC_BITS));
      s3_roll_r  <= s2_roll_r;
      s3_pitch_r <= s2_pitch_r;
    end
  end

  // stage 4: range test, first half of the divide by three
  // magnitudes of 2^34 and up saturate the corrected output either way
  logic signed [32:0] t200;
  logic [60:0]        cmag;
  logic [60:0]        cmag2;
  logic [33:0]        cmag_sat;
  logic [33:0]        qhi_prod;
  logic signed [31:0] s4_u_r;
  logic               s4_oor_r, s4_neg_r;
  logic [15:0]        s4_qhi_r;
  logic [1:0]         s4_rhi_r;
  logic [16:0]        s4_lo_r;
  logic [15:0]        qhi;
  logic [16:0]        qhi_x3;
  logic [16:0]        rhi_full;
  logic signed [13:0] s4_roll_r, s4_pitch_r;

  always_comb begin
    t200     = signed'(33'(base200_r)) + 33'(s3_u_r);
    cmag     = s3_corr0_r[60] ? 61'(-s3_corr0_r) : 61'(s3_corr0_r);
    cmag2    = {cmag[59:0], 1'b0};
    cmag_sat = (|cmag2[60:34]) ? '1 : cmag2[33:0];
    qhi_prod = 34'(cmag_sat[33:DIV3_SPLIT]) * 34'(DIV3_HI_MAGIC);
    qhi      = qhi_prod[33:DIV3_HI_SHIFT];
    qhi_x3   = 17'(qhi) + 17'(qhi) + 17'(qhi);
    rhi_full = cmag_sat[33:DIV3_SPLIT] - qhi_x3;
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_u_r     <= s3_u_r;
      s4_oor_r   <= (t200 < T200_LO) || (t200 > T200_HI);
      s4_neg_r   <= s3_corr0_r[60];
      s4_qhi_r   <= qhi;
      s4_rhi_r   <= rhi_full[1:0];
      s4_lo_r    <= cmag_sat[DIV3_SPLIT-1:0];
      s4_roll_r  <= s3_roll_r;
      s4_pitch_r <= s3_pitch_r;
    end
  end

  // stage 5: finish the divide, apply the correction
  logic [37:0]        qlo_prod;
  logic [32:0]        q3;
  logic signed [33:0] corr;
  logic signed [31:0] u2_nxt;
  logic signed [31:0] s5_u_r;
  logic               s5_lim_r;
  logic signed [13:0] s5_roll_r, s5_pitch_r;

  always_comb begin
    qlo_prod = 38'({s4_rhi_r, s4_lo_r}) * 38'(DIV3_LO_MAGIC);
    q3       = {s4_qhi_r, 17'b0} + 33'(qlo_prod[37:DIV3_LO_SHIFT]);
    corr     = s4_neg_r ? -signed'(34'(q3)) : signed'(34'(q3));
    u2_nxt   = s4_oor_r ? sat32(63'(s4_u_r) - 63'(corr)) : s4_u_r;
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_u_r     <= u2_nxt;
      s5_lim_r   <= s4_oor_r;
      s5_roll_r  <= s4_roll_r;
      s5_pitch_r <= s4_pitch_r;
    end
  end

  // stage 6: thrust clamp and scale, output register
  logic signed [32:0] t200b;
  logic [40:0]        thr_prod;
  logic [15:0]        thrust_nxt;
  logic [15:0]        out_thrust_cmd_r;
  logic signed [13:0] out_roll_cmd_r, out_pitch_cmd_r;
  logic               out_thrust_limited_r;

  always_comb begin
    t200b    = signed'(33'(base200_r)) + 33'(s5_u_r);
    thr_prod = 41'(t200b[22:3]) * 41'(DIV25_MAGIC);
    if (t200b < T200_LO) begin
      thrust_nxt = 16'(THR_LO);
    end else if (t200b > T200_HI) begin
      thrust_nxt = 16'(THR_HI);
    end else begin
      thrust_nxt = thr_prod[40:DIV25_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      out_thrust_cmd_r     <= thrust_nxt;
      out_roll_cmd_r       <= s5_roll_r;
      out_pitch_cmd_r      <= s5_pitch_r;
      out_thrust_limited_r <= s5_lim_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_thrust_cmd     = out_thrust_cmd_r;
  assign out_roll_cmd       = out_roll_cmd_r;
  assign out_pitch_cmd      = out_pitch_cmd_r;
  assign out_thrust_limited = out_thrust_limited_r;

endmodule

// ===== design/hptc_checker.sv =====
module hptc_checker import hptc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [15:0]       out_thrust_cmd,
  input logic signed [13:0] out_roll_cmd,
  input logic signed [13:0] out_pitch_cmd,
  input logic              out_thrust_limited
);

  a_rst_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_thrust_cmd) &&
      $stable(out_roll_cmd) && $stable(out_pitch_cmd) && $stable(out_thrust_limited))
    else $error("stalled request changed");

  a_thrust_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_thrust_cmd >= 16'(THR_LO) && out_thrust_cmd <= 16'(THR_HI))
    else $error("thrust outside 0.25..1.0");

  a_roll_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_roll_cmd == 14'sd0 ||
      (out_roll_cmd >= STICK_DEAD && out_roll_cmd <= STICK_MAX) ||
      (out_roll_cmd <= -STICK_DEAD && out_roll_cmd >= -STICK_MAX))
    else $error("roll command outside clamp or inside deadband");

  a_pitch_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pitch_cmd == 14'sd0 ||
      (out_pitch_cmd >= STICK_DEAD && out_pitch_cmd <= STICK_MAX) ||
      (out_pitch_cmd <= -STICK_DEAD && out_pitch_cmd >= -STICK_MAX))
    else $error("pitch command outside clamp or inside deadband");

endmodule

bind height_pidt1_thrust_controller hptc_checker u_hptc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_thrust_cmd     (out_thrust_cmd),
  .out_roll_cmd       (out_roll_cmd),
  .out_pitch_cmd      (out_pitch_cmd),
  .out_thrust_limited (out_thrust_limited)
);
